// File: hdl/rgb_median3x3_filter_assert.svh
`ifndef RGB_MEDIAN3X3_FILTER_ASSERT_SVH
`define RGB_MEDIAN3X3_FILTER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RGBMED_ASSERT_NOW(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RGBMED_ASSERT_NEXT(label, clk_s, rstn_s, ante, cons, msg) \
    label: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: hdl/rgbmed_pkg.sv
package rgbmed_pkg;

    localparam int PIX_W   = 24;
    localparam int CH_W    = 8;
    localparam int NUM_CH  = 3;
    localparam int X_W     = 10;
    localparam int Y_W     = 12;
    localparam int CFG_W_W = 11;
    localparam int CFG_H_W = 12;
    localparam int MIN_DIM = 3;

    localparam int DEFAULT_MAX_WIDTH = 1024;

    localparam logic [CFG_W_W-1:0] WIDTH_RESET  = 11'd1024;
    localparam logic [CFG_H_W-1:0] HEIGHT_RESET = 12'd768;

    localparam int APB_AW = 3;
    localparam int APB_DW = 32;

    localparam int M_TDATA_W = 48;
    localparam int M_PAD_W   = M_TDATA_W - PIX_W - X_W - Y_W;

    typedef logic [CH_W-1:0] chan_t;

    typedef enum logic {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic med_ok;
        logic border;
    } pos_flags_t;

endpackage

// File: hdl/rgbmed_ram.sv
module rgbmed_ram #(
    parameter int WIDTH = rgbmed_pkg::PIX_W,
    parameter int DEPTH = rgbmed_pkg::DEFAULT_MAX_WIDTH,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: hdl/rgbmed_pos.sv
module rgbmed_pos #(
    parameter int MAX_WIDTH = rgbmed_pkg::DEFAULT_MAX_WIDTH,
    localparam int CW = $clog2(MAX_WIDTH)
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             advance,
    input  logic                             frame_start,
    input  logic [rgbmed_pkg::CFG_W_W-1:0]   image_width,
    input  logic [rgbmed_pkg::CFG_H_W-1:0]   image_height,
    output logic [CW-1:0]                    cx,
    output logic [rgbmed_pkg::Y_W-1:0]       cy,
    output rgbmed_pkg::pos_flags_t           flags
);

    import rgbmed_pkg::*;

    localparam int WW = CW + 1;
    localparam logic [WW-1:0] MAXW = WW'(MAX_WIDTH);

    logic [CW-1:0]  col_reg, col_next;
    logic [Y_W-1:0] row_reg, row_next;
    logic [WW-1:0]  eff_w, col_cur, col_inc;
    logic [Y_W-1:0] eff_h, row_cur;
    logic [Y_W:0]   row_inc;

    always_comb
    begin
        if (int'(image_width) < MIN_DIM)
        begin
            eff_w = WW'(MIN_DIM);
        end
        else if (int'(image_width) > MAX_WIDTH)
        begin
            eff_w = MAXW;
        end
        else
        begin
            eff_w = WW'(image_width);
        end
        eff_h = (image_height < Y_W'(MIN_DIM)) ? Y_W'(MIN_DIM) : image_height;

        // A position left beyond a shrunken image wraps to the next row or frame.
        col_cur = frame_start ? '0 : {1'b0, col_reg};
        row_cur = frame_start ? '0 : row_reg;
        if (col_cur >= eff_w)
        begin
            col_cur = '0;
            row_cur = row_cur + Y_W'(1);
        end
        if (row_cur >= eff_h)
        begin
            row_cur = '0;
        end

        cx = col_cur[CW-1:0];
        cy = row_cur;

        col_inc  = col_cur + WW'(1);
        row_inc  = {1'b0, row_cur} + (Y_W + 1)'(1);
        col_next = col_inc[CW-1:0];
        row_next = row_cur;
        if (col_inc >= eff_w)
        begin
            col_next = '0;
            row_next = (row_inc >= {1'b0, eff_h}) ? '0 : row_inc[Y_W-1:0];
        end

        flags.med_ok = (col_cur >= WW'(2)) && (row_cur >= Y_W'(2));
        flags.border = (col_cur == '0) || (col_cur == eff_w - WW'(1)) ||
                       (row_cur == '0) || (row_cur == eff_h - Y_W'(1));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (advance)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

// File: hdl/rgbmed_med9.sv
module rgbmed_med9 (
    input  logic              clk,
    input  logic              advance,
    input  logic              load,
    input  rgbmed_pkg::chan_t col_top,
    input  rgbmed_pkg::chan_t col_mid,
    input  rgbmed_pkg::chan_t col_bot,
    output rgbmed_pkg::chan_t median
);

    import rgbmed_pkg::*;

    typedef struct packed {
        chan_t lo;
        chan_t md;
        chan_t hi;
    } col_t;

    function automatic chan_t min2(input chan_t a, input chan_t b);
        return (a < b) ? a : b;
    endfunction

    function automatic chan_t max2(input chan_t a, input chan_t b);
        return (a < b) ? b : a;
    endfunction

    function automatic chan_t med3(input chan_t a, input chan_t b, input chan_t c);
        return max2(min2(a, b), min2(max2(a, b), c));
    endfunction

    function automatic col_t sort3(input chan_t a, input chan_t b, input chan_t c);
        chan_t lo1;
        chan_t hi1;
        chan_t md2;
        chan_t hi2;
        lo1 = min2(a, b);
        hi1 = max2(a, b);
        md2 = min2(hi1, c);
        hi2 = max2(hi1, c);
        return '{lo: min2(lo1, md2), md: max2(lo1, md2), hi: hi2};
    endfunction

    // Columns are kept sorted; the window median is then the median of the
    // largest low, the middle median and the smallest high.
    col_t  k0_reg, k1_reg, k2_reg;
    chan_t lo_max_reg, md_med_reg, hi_min_reg;

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            if (load)
            begin
                k0_reg <= k1_reg;
                k1_reg <= k2_reg;
                k2_reg <= sort3(col_top, col_mid, col_bot);
            end
            lo_max_reg <= max2(max2(k0_reg.lo, k1_reg.lo), k2_reg.lo);
            md_med_reg <= med3(k0_reg.md, k1_reg.md, k2_reg.md);
            hi_min_reg <= min2(min2(k0_reg.hi, k1_reg.hi), k2_reg.hi);
        end
    end

    assign median = med3(lo_max_reg, md_med_reg, hi_min_reg);

endmodule

// File: hdl/rgb_median3x3_filter.sv
// Throughput: one item per cycle unless m_tready stalls the output; an item with two
// results (a median and a border pixel, on the right column and the bottom row) holds
// the input until its median is loaded. The line stores are two single-port-write RAMs,
// read as an item is accepted and written back from stage 1.
// Reset clears the position counters, the pipeline and the size registers (1024 x 768);
// the line stores are not cleared, so a frame must begin with frame_start.
`include "rgb_median3x3_filter_assert.svh"

module rgb_median3x3_filter #(
    parameter int MAX_WIDTH = rgbmed_pkg::DEFAULT_MAX_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // pixel_in[23:0]
    input  logic [rgbmed_pkg::PIX_W-1:0]      s_tdata,
    // frame_start[0]
    input  logic                              s_tuser,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // pixel_out[23:0], out_x[33:24], out_y[45:34], zero[47:46]
    output logic [rgbmed_pkg::M_TDATA_W-1:0]  m_tdata,
    output logic                              m_tlast,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [rgbmed_pkg::APB_AW-1:0]     paddr,
    input  logic [rgbmed_pkg::APB_DW-1:0]     pwdata,
    output logic [rgbmed_pkg::APB_DW-1:0]     prdata,
    output logic                              pready
);

    import rgbmed_pkg::*;

    localparam int CW = $clog2(MAX_WIDTH);

    // Configuration registers.
    logic [CFG_W_W-1:0] width_reg;
    logic [CFG_H_W-1:0] height_reg;
    logic               cfg_we;
    reg_idx_t           cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = reg_idx_t'(paddr[2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                REG_IMAGE_WIDTH:  width_reg  <= pwdata[CFG_W_W-1:0];
                REG_IMAGE_HEIGHT: height_reg <= pwdata[CFG_H_W-1:0];
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_idx)
            REG_IMAGE_WIDTH:  prdata = APB_DW'(width_reg);
            REG_IMAGE_HEIGHT: prdata = APB_DW'(height_reg);
        endcase
    end

    // Pipeline control.
    logic adv, accept, out_free, out_load;
    logic s3_med_reg, s3_med_next, s3_bord_reg, s3_bord_next;
    logic m_valid_reg, m_valid_next;

    assign out_free = !m_valid_reg || m_tready;
    assign out_load = out_free && (s3_med_reg || s3_bord_reg);
    assign adv      = !(s3_med_reg || s3_bord_reg) ||
                      (out_load && !(s3_med_reg && s3_bord_reg));
    assign accept   = s_tvalid && adv;
    assign s_tready = adv;

    // Position of the arriving pixel.
    logic [CW-1:0]  cx;
    logic [Y_W-1:0] cy;
    pos_flags_t     flags;

    rgbmed_pos #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_pos (
        .clk          (clk),
        .rst_n        (rst_n),
        .advance      (accept),
        .frame_start  (s_tuser),
        .image_width  (width_reg),
        .image_height (height_reg),
        .cx           (cx),
        .cy           (cy),
        .flags        (flags)
    );

    // Stage 1: line store read data arrives, write-back of the shifted column.
    logic             s1_valid_reg;
    logic [PIX_W-1:0] s1_pix_reg;
    logic [CW-1:0]    s1_cx_reg;
    logic [Y_W-1:0]   s1_cy_reg;
    pos_flags_t       s1_flags_reg;
    logic             fwd_reg;
    logic [PIX_W-1:0] fwd_top_reg, fwd_mid_reg;
    logic [PIX_W-1:0] upper_rdata, middle_rdata, top_val, mid_val;
    logic             ram_we;

    assign ram_we  = adv && s1_valid_reg;
    assign top_val = fwd_reg ? fwd_top_reg : upper_rdata;
    assign mid_val = fwd_reg ? fwd_mid_reg : middle_rdata;

    rgbmed_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_cx_reg),
        .wdata (mid_val),
        .re    (accept),
        .raddr (cx),
        .rdata (upper_rdata)
    );

    rgbmed_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle_line (
        .clk   (clk),
        .we    (ram_we),
        .waddr (s1_cx_reg),
        .wdata (s1_pix_reg),
        .re    (accept),
        .raddr (cx),
        .rdata (middle_rdata)
    );

    // Stage 2 and 3 payload.
    logic             s2_valid_reg;
    logic [PIX_W-1:0] s2_pix_reg, s3_pix_reg;
    logic [CW-1:0]    s2_cx_reg, s3_cx_reg;
    logic [Y_W-1:0]   s2_cy_reg, s3_cy_reg;
    pos_flags_t       s2_flags_reg;
    logic [PIX_W-1:0] med_pix;

    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_chan
        rgbmed_med9 u_med9 (
            .clk     (clk),
            .advance (adv),
            .load    (s1_valid_reg),
            .col_top (top_val[ch*CH_W +: CH_W]),
            .col_mid (mid_val[ch*CH_W +: CH_W]),
            .col_bot (s1_pix_reg[ch*CH_W +: CH_W]),
            .median  (med_pix[ch*CH_W +: CH_W])
        );
    end

    always_comb
    begin
        s3_med_next  = s3_med_reg;
        s3_bord_next = s3_bord_reg;
        if (adv)
        begin
            s3_med_next  = s2_valid_reg && s2_flags_reg.med_ok;
            s3_bord_next = s2_valid_reg && s2_flags_reg.border;
        end
        else if (out_load)
        begin
            if (s3_med_reg)
            begin
                s3_med_next = 1'b0;
            end
            else
            begin
                s3_bord_next = 1'b0;
            end
        end
        m_valid_next = out_load || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_med_reg   <= 1'b0;
            s3_bord_reg  <= 1'b0;
            m_valid_reg  <= 1'b0;
            fwd_reg      <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                s1_valid_reg <= s_tvalid;
                s2_valid_reg <= s1_valid_reg;
            end
            if (accept)
            begin
                fwd_reg <= ram_we && (s1_cx_reg == cx);
            end
            s3_med_reg  <= s3_med_next;
            s3_bord_reg <= s3_bord_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Output register.
    logic [PIX_W-1:0] out_pix_reg;
    logic [X_W-1:0]   out_x_reg;
    logic [Y_W-1:0]   out_y_reg;
    logic             out_last_reg;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg   <= s_tdata;
            s1_cx_reg    <= cx;
            s1_cy_reg    <= cy;
            s1_flags_reg <= flags;
            fwd_top_reg  <= mid_val;
            fwd_mid_reg  <= s1_pix_reg;
        end
        if (adv)
        begin
            s2_pix_reg   <= s1_pix_reg;
            s2_cx_reg    <= s1_cx_reg;
            s2_cy_reg    <= s1_cy_reg;
            s2_flags_reg <= s1_flags_reg;
            s3_pix_reg   <= s2_pix_reg;
            s3_cx_reg    <= s2_cx_reg;
            s3_cy_reg    <= s2_cy_reg;
        end
        if (out_load)
        begin
            if (s3_med_reg)
            begin
                out_pix_reg  <= med_pix;
                out_x_reg    <= X_W'(s3_cx_reg - CW'(1));
                out_y_reg    <= s3_cy_reg - Y_W'(1);
                out_last_reg <= !s3_bord_reg;
            end
            else
            begin
                out_pix_reg  <= s3_pix_reg;
                out_x_reg    <= X_W'(s3_cx_reg);
                out_y_reg    <= s3_cy_reg;
                out_last_reg <= 1'b1;
            end
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {{M_PAD_W{1'b0}}, out_y_reg, out_x_reg, out_pix_reg};
    assign m_tlast  = out_last_reg;

    `RGBMED_ASSERT_NOW(a_pair_blocks_input, clk, rst_n, s3_med_reg && s3_bord_reg, !adv, "item with two pending results let the pipeline advance")
    `RGBMED_ASSERT_NEXT(a_line_data_held, clk, rst_n, s1_valid_reg && !adv, $stable(top_val) && $stable(mid_val), "line store data changed under a stalled item")
    `RGBMED_ASSERT_NOW(a_median_then_border, clk, rst_n, m_valid_reg && !out_last_reg, s3_bord_reg && !s3_med_reg, "median result not followed by its border result")

endmodule

// File: tb/rgb_median3x3_filter_test.sv
module rgb_median3x3_filter_test;
    timeunit 1ns;
    timeprecision 1ps;

    import rgbmed_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 700;
    localparam int unsigned SETTLE_CYCLES = 12;
    localparam int unsigned RUN_LIMIT_NS = 2_500_000;
    localparam int unsigned MAX_GAP = 14;

    localparam logic [CH_W-1:0] EDGE_LEVELS [4] = '{8'h00, 8'h01, 8'hFE, 8'hFF};

    localparam logic [PIX_W-1:0] CORNER_PIXELS [25] = '{
        24'h000000, 24'hFFFFFF, 24'hAAAAAA, 24'h555555, 24'hFF00FF,
        24'h00FF00, 24'h123456, 24'hFEDCBA, 24'h0F0F0F,
        24'h800000, 24'h008000, 24'h000080, 24'h7F7F7F,
        24'hFFFFFF, 24'hFFFFFF, 24'h000000, 24'h000000, 24'h010203,
        24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000,
        24'h000000, 24'hFFFFFF, 24'h800080
    };

    typedef struct packed {
        logic [PIX_W-1:0] pix;
        logic [X_W-1:0]   x;
        logic [Y_W-1:0]   y;
        logic             last;
    } median_result_t;

    class rgb_median_scoreboard;
        logic [CFG_W_W-1:0] width_reg;
        logic [CFG_H_W-1:0] height_reg;
        logic [PIX_W-1:0]   upper_row [DEFAULT_MAX_WIDTH];
        logic [PIX_W-1:0]   middle_row [DEFAULT_MAX_WIDTH];
        logic [PIX_W-1:0]   window_cols [6];
        int unsigned        col_pos;
        int unsigned        row_pos;
        median_result_t     pending_pixels [$];
        int unsigned        errors;

        function new();
            width_reg = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (upper_row[i])
            begin
                upper_row[i] = '0;
                middle_row[i] = '0;
            end
            foreach (window_cols[i])
            begin
                window_cols[i] = '0;
            end
            col_pos = 0;
            row_pos = 0;
            errors = 0;
        endfunction

        function void write_reg(reg_idx_t idx, logic [APB_DW-1:0] value);
            if (idx == REG_IMAGE_WIDTH)
            begin
                width_reg = value[CFG_W_W-1:0];
            end
            else
            begin
                height_reg = value[CFG_H_W-1:0];
            end
        endfunction

        function int unsigned eff_width();
            if (width_reg < MIN_DIM)
            begin
                return MIN_DIM;
            end
            if (width_reg > DEFAULT_MAX_WIDTH)
            begin
                return DEFAULT_MAX_WIDTH;
            end
            return 32'(width_reg);
        endfunction

        function int unsigned eff_height();
            if (height_reg < MIN_DIM)
            begin
                return MIN_DIM;
            end
            return 32'(height_reg);
        endfunction

        function logic [CH_W-1:0] channel_median(logic [PIX_W-1:0] nbr [9], int unsigned ch);
            logic [CH_W-1:0] v [9];
            logic [CH_W-1:0] key;
            int              i;
            int              j;
            for (i = 0; i < 9; i++)
            begin
                v[i] = nbr[i][ch*CH_W +: CH_W];
            end
            for (i = 1; i < 9; i++)
            begin
                key = v[i];
                j = i - 1;
                while (j >= 0 && v[j] > key)
                begin
                    v[j+1] = v[j];
                    j--;
                end
                v[j+1] = key;
            end
            return v[4];
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix, logic frame_first);
            int unsigned      w;
            int unsigned      h;
            int unsigned      cx;
            int unsigned      cy;
            int unsigned      made;
            logic [PIX_W-1:0] top;
            logic [PIX_W-1:0] mid;
            logic [PIX_W-1:0] nbr [9];
            median_result_t   res [2];
            w = eff_width();
            h = eff_height();
            if (frame_first)
            begin
                col_pos = 0;
                row_pos = 0;
            end
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos++;
            end
            if (row_pos >= h)
            begin
                row_pos = 0;
            end
            cx = col_pos;
            cy = row_pos;
            top = upper_row[cx];
            mid = middle_row[cx];
            made = 0;
            if (cx >= 2 && cy >= 2)
            begin
                for (int k = 0; k < 6; k++)
                begin
                    nbr[k] = window_cols[k];
                end
                nbr[6] = top;
                nbr[7] = mid;
                nbr[8] = pix;
                res[made].pix = {channel_median(nbr, 2), channel_median(nbr, 1),
                                 channel_median(nbr, 0)};
                res[made].x = X_W'(cx - 1);
                res[made].y = Y_W'(cy - 1);
                res[made].last = 1'b0;
                made++;
            end
            if (cx == 0 || cx == w - 1 || cy == 0 || cy == h - 1)
            begin
                res[made].pix = pix;
                res[made].x = X_W'(cx);
                res[made].y = Y_W'(cy);
                res[made].last = 1'b0;
                made++;
            end
            for (int k = 0; k < made; k++)
            begin
                res[k].last = (k == made - 1);
                pending_pixels.push_back(res[k]);
            end
            window_cols[0] = window_cols[3];
            window_cols[1] = window_cols[4];
            window_cols[2] = window_cols[5];
            window_cols[3] = top;
            window_cols[4] = mid;
            window_cols[5] = pix;
            upper_row[cx] = mid;
            middle_row[cx] = pix;
            col_pos = cx + 1;
            if (col_pos >= w)
            begin
                col_pos = 0;
                row_pos = cy + 1;
                if (row_pos >= h)
                begin
                    row_pos = 0;
                end
            end
        endfunction

        function void check_pixel(logic [M_TDATA_W-1:0] data, logic last);
            median_result_t want;
            if (pending_pixels.size() == 0)
            begin
                $display("%0t: output item with nothing expected, expected none got %h last %b",
                         $time, data, last);
                errors++;
                return;
            end
            want = pending_pixels.pop_front();
            if (data[PIX_W-1:0] !== want.pix)
            begin
                $display("%0t: pixel_out expected %h got %h", $time, want.pix, data[PIX_W-1:0]);
                errors++;
            end
            if (data[PIX_W +: X_W] !== want.x)
            begin
                $display("%0t: out_x expected %0d got %0d", $time, want.x, data[PIX_W +: X_W]);
                errors++;
            end
            if (data[PIX_W+X_W +: Y_W] !== want.y)
            begin
                $display("%0t: out_y expected %0d got %0d", $time, want.y,
                         data[PIX_W+X_W +: Y_W]);
                errors++;
            end
            if (data[M_TDATA_W-1 -: M_PAD_W] !== '0)
            begin
                $display("%0t: tdata padding expected 0 got %b", $time,
                         data[M_TDATA_W-1 -: M_PAD_W]);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: last_of_run expected %b got %b", $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [PIX_W-1:0]       s_tdata;
    logic                   s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [M_TDATA_W-1:0]   m_tdata;
    logic                   m_tlast;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_AW-1:0]      paddr;
    logic [APB_DW-1:0]      pwdata;
    logic [APB_DW-1:0]      prdata;
    logic                   pready;

    rgb_median_scoreboard sb = new();
    bit src_steady = 1'b0;

    rgb_median3x3_filter u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #1 clk = ~clk;

    task automatic apb_write(input reg_idx_t idx, input logic [APB_DW-1:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic apb_read(input reg_idx_t idx, output logic [APB_DW-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= {idx, 2'b00};
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        data = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic check_regs();
        logic [APB_DW-1:0] got;
        apb_read(REG_IMAGE_WIDTH, got);
        if (got !== APB_DW'(sb.width_reg))
        begin
            $display("%0t: image_width readback expected %0d got %0d", $time, sb.width_reg, got);
            sb.errors++;
        end
        apb_read(REG_IMAGE_HEIGHT, got);
        if (got !== APB_DW'(sb.height_reg))
        begin
            $display("%0t: image_height readback expected %0d got %0d", $time, sb.height_reg,
                     got);
            sb.errors++;
        end
    endtask

    task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic frame_first);
        int unsigned gap;
        if ($urandom_range(0, 39) == 0)
        begin
            src_steady = !src_steady;
        end
        gap = src_steady ? 0 : $urandom_range(0, MAX_GAP);
        if (gap != 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= pix;
        s_tuser <= frame_first;
        do @(posedge clk); while (!s_tready);
        sb.note_pixel(pix, frame_first);
    endtask

    // Drain everything in flight, including items that produce no output.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending_pixels.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [APB_DW-1:0] pick_size(reg_idx_t idx);
        logic [APB_DW-1:0] v;
        if (idx == REG_IMAGE_WIDTH)
        begin
            case ($urandom_range(0, 9))
                0: v = $urandom_range(0, 2);
                1: v = $urandom_range(13, 40);
                default: v = $urandom_range(3, 12);
            endcase
        end
        else
        begin
            case ($urandom_range(0, 9))
                0: v = $urandom_range(0, 2);
                1: v = 4095;
                2: v = $urandom_range(9, 20);
                default: v = $urandom_range(3, 8);
            endcase
        end
        if ($urandom_range(0, 7) == 0)
        begin
            v[APB_DW-1:CFG_H_W] = (APB_DW-CFG_H_W)'($urandom());
        end
        return v;
    endfunction

    function automatic logic [PIX_W-1:0] random_pixel(int unsigned tone);
        logic [PIX_W-1:0] p;
        int unsigned      c;
        p = PIX_W'($urandom());
        for (c = 0; c < NUM_CH; c++)
        begin
            if (tone == 1)
            begin
                p[c*CH_W +: CH_W] = EDGE_LEVELS[$urandom_range(0, 3)];
            end
            else if (tone == 2)
            begin
                p[c*CH_W +: CH_W] = CH_W'($urandom_range(0, 3));
            end
        end
        return p;
    endfunction

    initial
    begin
        int unsigned gap;
        bit          sink_steady;
        sink_steady = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if ($urandom_range(0, 39) == 0)
            begin
                sink_steady = !sink_steady;
            end
            gap = sink_steady ? 0 : $urandom_range(0, MAX_GAP);
            if (gap != 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (!m_tvalid);
            sb.check_pixel(m_tdata, m_tlast);
        end
    end

    initial
    begin
        int unsigned random_items;
        int unsigned count;
        int unsigned w;
        int unsigned h;
        int unsigned old_w;
        int unsigned tone;
        bit          restart;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        check_regs();

        // Smallest image: full frame, a partial frame cut off by a new frame start,
        // then a full frame, then continuation after out-of-range sizes.
        apb_write(REG_IMAGE_WIDTH, 3);
        apb_write(REG_IMAGE_HEIGHT, 3);
        check_regs();
        for (int i = 0; i < 22; i++)
        begin
            send_pixel(CORNER_PIXELS[i], (i == 0) || (i == 13));
        end
        settle();
        apb_write(REG_IMAGE_WIDTH, 0);
        apb_write(REG_IMAGE_HEIGHT, 1);
        check_regs();
        for (int i = 22; i < 25; i++)
        begin
            send_pixel(CORNER_PIXELS[i], 1'b0);
        end
        settle();

        // Widest row through an oversized width value.
        apb_write(REG_IMAGE_WIDTH, 32'h0000_07FF);
        apb_write(REG_IMAGE_HEIGHT, 3);
        check_regs();
        for (int i = 0; i < DEFAULT_MAX_WIDTH; i++)
        begin
            send_pixel(random_pixel($urandom_range(0, 2)), i == 0);
        end

        random_items = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            settle();
            old_w = sb.eff_width();
            if ($urandom_range(0, 3) != 0)
            begin
                apb_write(REG_IMAGE_WIDTH, pick_size(REG_IMAGE_WIDTH));
            end
            if ($urandom_range(0, 3) != 0)
            begin
                apb_write(REG_IMAGE_HEIGHT, pick_size(REG_IMAGE_HEIGHT));
            end
            if ($urandom_range(0, 4) == 0)
            begin
                check_regs();
            end
            w = sb.eff_width();
            h = sb.eff_height();
            // A wider row would read line entries never written in this frame.
            restart = (w > old_w) || ($urandom_range(0, 1) == 1);
            if (w * h <= 120)
            begin
                count = w * h * $urandom_range(1, 2) + $urandom_range(0, 2 * w);
            end
            else
            begin
                count = w * $urandom_range(3, 8) + $urandom_range(0, w);
            end
            tone = $urandom_range(0, 2);
            for (int i = 0; i < count; i++)
            begin
                send_pixel(random_pixel(tone), (i == 0 && restart) || ($urandom_range(0, 59) == 0));
            end
            random_items += count;
        end

        settle();
        if (sb.errors == 0)
        begin
            $display("Testbench completed without errors");
        end
        else
        begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

    initial
    begin
        #RUN_LIMIT_NS;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: rgb_median3x3_filter.f
+incdir+hdl
hdl/rgbmed_pkg.sv
hdl/rgbmed_ram.sv
hdl/rgbmed_pos.sv
hdl/rgbmed_med9.sv
hdl/rgb_median3x3_filter.sv
tb/rgb_median3x3_filter_test.sv
